// ===== sv/esdt_pkg.sv =====
// Shared types, constants and the month-length table for the epoch-to-date converter.
package esdt_pkg;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;

	// Reciprocals of 675, 225 and 15 after the power-of-two part of each divisor is shifted out
	localparam logic [25:0] DAY_RECIP  = 26'd50903317;
	localparam logic [13:0] HOUR_RECIP = 14'd9321;
	localparam logic [10:0] MIN_RECIP  = 11'd1093;

	localparam int unsigned DayShift  = 35;
	localparam int unsigned HourShift = 21;
	localparam int unsigned MinShift  = 14;

	localparam logic [11:0] FIRST_YEAR   = 12'd1970;
	localparam logic [6:0]  FIRST_MOD100 = 7'd70;
	localparam logic [8:0]  FIRST_MOD400 = 9'd370;
	localparam logic [8:0]  YEAR_DAYS    = 9'd365;
	localparam logic [8:0]  LEAP_DAYS    = 9'd366;
	localparam logic [3:0]  LAST_MONTH   = 4'd11;
	localparam logic [3:0]  FEBRUARY     = 4'd1;

	typedef enum logic [1:0] {
		DIV_DAY  = 2'd0,
		DIV_HOUR = 2'd1,
		DIV_MIN  = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     step_div;
		div_sel_t div_sel;
		logic     step_year;
		logic     step_month;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic year_done;
		logic month_done;
	} sts_t;

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== sv/esdt_dp.sv =====
// Datapath: reciprocal-multiply divider, year and month peeling, output registers.
module esdt_dp (
	input  logic                clk,
	input  esdt_pkg::cmd_t      cmd,
	output esdt_pkg::sts_t      sts,
	input  logic [31:0]         epoch_seconds,
	output logic [4:0]          day_of_month,
	output logic [3:0]          month_number,
	output logic [11:0]         year_number,
	output logic [4:0]          hour_of_day,
	output logic [5:0]          minute_of_hour,
	output logic [5:0]          second_of_minute
);

	logic [31:0] rem_q, rem_nx;
	logic [15:0] quo_q, quo_sel;
	logic        rem_phase_q;
	logic [50:0] day_prod;
	logic [26:0] hour_prod;
	logic [20:0] min_prod;
	logic [16:0] dvs_sel;
	logic [31:0] back_prod;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [6:0]  mod100_q;
	logic [8:0]  mod400_q;
	logic [3:0]  month_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q, second_q;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic [4:0]  day_of_month_q;
	logic [3:0]  month_number_q;
	logic [11:0] year_number_q;
	logic [4:0]  hour_of_day_q;
	logic [5:0]  minute_of_hour_q, second_of_minute_q;

	assign day_prod  = 51'(rem_q[31:7]) * 51'(esdt_pkg::DAY_RECIP);
	assign hour_prod = 27'(rem_q[16:4]) * 27'(esdt_pkg::HOUR_RECIP);
	assign min_prod  = 21'(rem_q[11:2]) * 21'(esdt_pkg::MIN_RECIP);

	always_comb begin
		case (cmd.div_sel)
			esdt_pkg::DIV_DAY: begin
				quo_sel = 16'(day_prod >> esdt_pkg::DayShift);
				dvs_sel = 17'(esdt_pkg::SecsPerDay);
			end
			esdt_pkg::DIV_HOUR: begin
				quo_sel = 16'(hour_prod >> esdt_pkg::HourShift);
				dvs_sel = 17'(esdt_pkg::SecsPerHour);
			end
			default: begin
				quo_sel = 16'(min_prod >> esdt_pkg::MinShift);
				dvs_sel = 17'(esdt_pkg::SecsPerMin);
			end
		endcase
	end

	assign back_prod = 32'(quo_q) * 32'(dvs_sel);
	assign rem_nx    = rem_q - back_prod;

	assign leap = (year_q[1:0] == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
	assign ylen = leap ? esdt_pkg::LEAP_DAYS : esdt_pkg::YEAR_DAYS;
	assign mlen = esdt_pkg::month_len(month_q, leap);

	assign sts.div_last   = rem_phase_q;
	assign sts.year_done  = days_q < 16'(ylen);
	assign sts.month_done = (month_q == esdt_pkg::LAST_MONTH) || (days_q < 16'(mlen));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q       <= epoch_seconds;
			rem_phase_q <= 1'b0;
			year_q      <= esdt_pkg::FIRST_YEAR;
			mod100_q    <= esdt_pkg::FIRST_MOD100;
			mod400_q    <= esdt_pkg::FIRST_MOD400;
			month_q     <= '0;
		end else if (cmd.step_div) begin
			if (!rem_phase_q) begin
				quo_q       <= quo_sel;
				rem_phase_q <= 1'b1;
			end else begin
				rem_q       <= rem_nx;
				rem_phase_q <= 1'b0;
				case (cmd.div_sel)
					esdt_pkg::DIV_DAY: begin
						days_q <= quo_q;
					end
					esdt_pkg::DIV_HOUR: begin
						hour_q <= quo_q[4:0];
					end
					default: begin
						minute_q <= quo_q[5:0];
						second_q <= rem_nx[5:0];
					end
				endcase
			end
		end else if (cmd.step_year && !sts.year_done) begin
			days_q   <= days_q - 16'(ylen);
			year_q   <= year_q + 12'd1;
			mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
		end else if (cmd.step_month && !sts.month_done) begin
			days_q  <= days_q - 16'(mlen);
			month_q <= month_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			day_of_month_q     <= days_q[4:0] + 5'd1;
			month_number_q     <= month_q + 4'd1;
			year_number_q      <= year_q;
			hour_of_day_q      <= hour_q;
			minute_of_hour_q   <= minute_q;
			second_of_minute_q <= second_q;
		end
	end

	assign day_of_month     = day_of_month_q;
	assign month_number     = month_number_q;
	assign year_number      = year_number_q;
	assign hour_of_day      = hour_of_day_q;
	assign minute_of_hour   = minute_of_hour_q;
	assign second_of_minute = second_of_minute_q;

	a_year_adv: assert property (@(posedge clk)
		cmd.step_year && !sts.year_done |=> year_q == $past(year_q) + 12'd1)
		else $error("year counter did not advance on a year step");

	a_month_range: assert property (@(posedge clk)
		cmd.step_month |-> days_q < 16'(esdt_pkg::LEAP_DAYS) && month_q <= esdt_pkg::LAST_MONTH)
		else $error("month phase entered with too many days or bad month");

	a_out_day: assert property (@(posedge clk)
		cmd.out_load |-> days_q < 16'd31)
		else $error("day of month out of range at output load");

endmodule

// ===== sv/esdt_ctrl.sv =====
// Controller: sequences division, year and month phases and owns the handshakes.
module esdt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output esdt_pkg::cmd_t cmd,
	input  esdt_pkg::sts_t sts
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DAY   = 7'b0000010,
		S_HOUR  = 7'b0000100,
		S_MIN   = 7'b0001000,
		S_YEAR  = 7'b0010000,
		S_MONTH = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx       = state_q;
		cmd            = '0;
		cmd.div_sel    = esdt_pkg::DIV_DAY;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_DAY;
				end
			end
			S_DAY: begin
				cmd.step_div = 1'b1;
				if (sts.div_last) state_nx = S_HOUR;
			end
			S_HOUR: begin
				cmd.step_div = 1'b1;
				cmd.div_sel  = esdt_pkg::DIV_HOUR;
				if (sts.div_last) state_nx = S_MIN;
			end
			S_MIN: begin
				cmd.step_div = 1'b1;
				cmd.div_sel  = esdt_pkg::DIV_MIN;
				if (sts.div_last) state_nx = S_YEAR;
			end
			S_YEAR: begin
				cmd.step_year = 1'b1;
				if (sts.year_done) state_nx = S_MONTH;
			end
			S_MONTH: begin
				cmd.step_month = 1'b1;
				if (sts.month_done) state_nx = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DAY)
		else $error("accepted item did not start the day division");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("result left DONE while the output slot was busy");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("output load did not raise out_valid");

endmodule

// ===== sv/epoch_seconds_to_date_time.sv =====
// Top level: epoch seconds to Gregorian date and time of day.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | epoch_seconds
//  out     | output    | out_valid / out_ready| day_of_month .. second_of_minute
//
// One item at a time: an accept step, then a quotient and a remainder step each for day,
// hour and minute, a year loop that peels one year per cycle, a month loop, and a step
// that loads the result.
// A finished result waits in the output register; the next item is accepted meanwhile.
// While that result waits, the next one holds in its final cycle and the input stalls.
// Reset clears the controller and the output valid flag; no clearing pass.
module epoch_seconds_to_date_time (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_number,
	output logic [11:0] year_number,
	output logic [4:0]  hour_of_day,
	output logic [5:0]  minute_of_hour,
	output logic [5:0]  second_of_minute
);

	esdt_pkg::cmd_t cmd;
	esdt_pkg::sts_t sts;

	esdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	esdt_dp u_dp (
		.clk              (clk),
		.cmd              (cmd),
		.sts              (sts),
		.epoch_seconds    (epoch_seconds),
		.day_of_month     (day_of_month),
		.month_number     (month_number),
		.year_number      (year_number),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute)
	);

endmodule

// ===== dv/epoch_seconds_to_date_time_tb.sv =====
// Self-checking testbench for the epoch-seconds to calendar date and time converter.
module epoch_seconds_to_date_time_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems  = 1126;
	localparam int StallAt      = 30;
	localparam int StallCycles  = 1500;
	localparam int WatchdogMax  = 8000;
	localparam int TailCycles   = 200;
	localparam int CalmFirst    = 300;
	localparam int CalmLast     = 450;
	localparam int PauseAt      = 600;
	localparam int DirectedRows = 24;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} date_time_t;

	typedef struct packed {
		logic [31:0] secs;
		logic        typed;
		date_time_t  want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] epoch_seconds = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  day_of_month;
	logic [3:0]  month_number;
	logic [11:0] year_number;
	logic [4:0]  hour_of_day;
	logic [5:0]  minute_of_hour;
	logic [5:0]  second_of_minute;

	date_time_t pending_dates[$];
	bit         calm = 1'b0;
	bit         failed = 1'b0;
	int         mismatch_count = 0;
	int         dates_seen = 0;

	stim_row_t directed_rows [DirectedRows] = '{
		'{32'd0,          1'b1, '{5'd1,  4'd1, 12'd1970, 5'd0, 6'd0,  6'd0}},
		'{32'hFFFFFFFF,   1'b1, '{5'd7,  4'd2, 12'd2106, 5'd6, 6'd28, 6'd15}},
		'{32'h7FFFFFFF,   1'b1, '{5'd19, 4'd1, 12'd2038, 5'd3, 6'd14, 6'd7}},
		'{32'h80000000,   1'b1, '{5'd19, 4'd1, 12'd2038, 5'd3, 6'd14, 6'd8}},
		'{32'd59,         1'b0, '0},
		'{32'd60,         1'b0, '0},
		'{32'd3599,       1'b0, '0},
		'{32'd3600,       1'b0, '0},
		'{32'd86399,      1'b0, '0},
		'{32'd86400,      1'b0, '0},
		'{32'd2678399,    1'b0, '0},
		'{32'd2678400,    1'b0, '0},
		'{32'd31535999,   1'b0, '0},
		'{32'd31536000,   1'b0, '0},
		'{32'd68169600,   1'b0, '0},
		'{32'd94608000,   1'b0, '0},
		'{32'd94694399,   1'b0, '0},
		'{32'd94694400,   1'b0, '0},
		'{32'd951782400,  1'b0, '0},
		'{32'd978220800,  1'b0, '0},
		'{32'd4107542399, 1'b0, '0},
		'{32'd4107542400, 1'b0, '0},
		'{32'h55555555,   1'b0, '0},
		'{32'hAAAAAAAA,   1'b0, '0}
	};

	epoch_seconds_to_date_time DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.day_of_month     (day_of_month),
		.month_number     (month_number),
		.year_number      (year_number),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_leap(input int unsigned year);
		return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
	endfunction

	function automatic date_time_t to_calendar(input logic [31:0] secs);
		int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		int unsigned days;
		int unsigned tod;
		int unsigned year;
		int unsigned month;
		int unsigned year_len;
		int unsigned month_len_now;
		bit          leap;
		date_time_t  r;
		days  = secs / esdt_pkg::SecsPerDay;
		tod   = secs % esdt_pkg::SecsPerDay;
		year  = esdt_pkg::FIRST_YEAR;
		month = 0;
		year_len = is_leap(year) ? 366 : 365;
		while (days >= year_len) begin
			days -= year_len;
			year++;
			year_len = is_leap(year) ? 366 : 365;
		end
		leap = is_leap(year);
		while (month < 11) begin
			month_len_now = (month == 1 && leap) ? 29 : month_days[month];
			if (days < month_len_now)
				break;
			days -= month_len_now;
			month++;
		end
		r.day    = 5'(days + 1);
		r.month  = 4'(month + 1);
		r.year   = 12'(year);
		r.hour   = 5'(tod / esdt_pkg::SecsPerHour);
		r.minute = 6'((tod % esdt_pkg::SecsPerHour) / esdt_pkg::SecsPerMin);
		r.second = 6'(tod % esdt_pkg::SecsPerMin);
		return r;
	endfunction

	task automatic queue_date(input date_time_t d);
		pending_dates = {pending_dates, d};
	endtask

	task automatic offer_item(input logic [31:0] secs);
		while (!calm && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_dates();
		in_valid <= 1'b0;
		wait (pending_dates.size() == 0);
		@(posedge clk);
	endtask

	// receive side: check each date, random stalls, one long hold
	initial begin
		date_time_t got;
		date_time_t want;
		int         hold_left;
		bit         held;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{day_of_month, month_number, year_number,
					hour_of_day, minute_of_hour, second_of_minute};
				dates_seen++;
				if (pending_dates.size() == 0) begin
					failed = 1'b1;
					if (mismatch_count < 10)
						$display("unexpected date %0d-%0d-%0d %0d:%0d:%0d",
							got.year, got.month, got.day, got.hour, got.minute, got.second);
					mismatch_count++;
				end else begin
					want = pending_dates.pop_front();
					if (got !== want) begin
						failed = 1'b1;
						if (mismatch_count < 10)
							$display("date mismatch: want %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
								want.year, want.month, want.day, want.hour, want.minute, want.second,
								got.year, got.month, got.day, got.hour, got.minute, got.second);
						mismatch_count++;
					end
				end
			end
			if (dates_seen == StallAt && !held) begin
				held      = 1'b1;
				hold_left = StallCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= calm || ($urandom_range(0, 99) >= 6);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WatchdogMax) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [31:0] secs;
		logic [63:0] stamp;
		int          mode;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer_item(directed_rows[i].secs);
			queue_date(directed_rows[i].typed ? directed_rows[i].want
				: to_calendar(directed_rows[i].secs));
		end
		drain_dates();

		for (int n = 0; n < RandomItems; n++) begin
			calm = (n >= CalmFirst) && (n < CalmLast);
			if (n == PauseAt)
				drain_dates();
			mode = $urandom_range(0, 9);
			if (mode < 5)
				secs = $urandom();
			else if (mode < 8) begin
				stamp = 64'($urandom_range(0, 49710)) * esdt_pkg::SecsPerDay;
				case ($urandom_range(0, 2))
					0:       stamp = stamp;
					1:       stamp = stamp + esdt_pkg::SecsPerDay - 1;
					default: stamp = stamp + $urandom_range(0, esdt_pkg::SecsPerDay - 1);
				endcase
				secs = (stamp > 64'hFFFFFFFF) ? $urandom() : stamp[31:0];
			end else if (mode == 8)
				secs = $urandom_range(0, 1000000);
			else
				secs = 32'hFFFFFFFF - $urandom_range(0, 20000000);
			offer_item(secs);
			queue_date(to_calendar(secs));
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		wait (pending_dates.size() == 0);
		repeat (TailCycles) @(posedge clk);
		if (!failed && pending_dates.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
